[rtl/cbcs_pkg.sv]
// ----------------------------------------------------------------------------
// cbcs_pkg
// Shared widths, payload structs, register codes and helpers for the
// color blob centroid steering block.
// ----------------------------------------------------------------------------
package cbcs_pkg;

    // largest frame side handled, widths below follow from it
    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CNT_W      = 2 * DIM_W + 1;
    localparam int SUM_W      = 3 * DIM_W;
    localparam int NUM_W      = SUM_W + 4;
    localparam int DEN_W      = CNT_W + DIM_W + 1;
    localparam int ITER_W     = $clog2(NUM_W);

    // fixed field widths
    localparam int COLOR_W    = 8;
    localparam int TOL_W      = 10;
    localparam int DREG_W     = 11;
    localparam int MC_W       = 21;
    localparam int CEN_W      = 10;
    localparam int CMD_W      = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // frame record queue
    localparam int QDEPTH     = 2;
    localparam int Q_PTR_W    = $clog2(QDEPTH);
    localparam int Q_CNT_W    = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_RED   = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_BLUE  = 3'd2,
        REG_MATCH_TOL    = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5,
        REG_MIN_COUNT    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_blue;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_red;
    } pixel_t;

    typedef struct packed {
        logic [MC_W-1:0]         match_count;
        logic [CEN_W-1:0]        centroid_x;
        logic [CEN_W-1:0]        centroid_y;
        logic signed [CMD_W-1:0] turn_tenths;
        logic signed [CMD_W-1:0] forward_tenths;
        logic                    target_seen;
    } result_t;

    typedef struct packed {
        logic [COLOR_W-1:0] target_red;
        logic [COLOR_W-1:0] target_green;
        logic [COLOR_W-1:0] target_blue;
        logic [TOL_W-1:0]   match_tolerance;
        logic [DREG_W-1:0]  frame_width;
        logic [DREG_W-1:0]  frame_height;
        logic [MC_W-1:0]    min_count;
    } cfg_t;

    // everything the back end needs about one finished frame
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] col_sum;
        logic [SUM_W-1:0] row_sum;
        logic [DIM_W:0]   width;
        logic [DIM_W:0]   height;
        logic [MC_W-1:0]  min_count;
    } frame_rec_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
        logic             rem_nz;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CX_GO,
        ST_CX_WAIT,
        ST_CY_GO,
        ST_CY_WAIT,
        ST_TX_MUL,
        ST_TX_GO,
        ST_TX_WAIT,
        ST_TY_MUL,
        ST_TY_GO,
        ST_TY_WAIT,
        ST_EMIT
    } back_state_t;

    // frame side limited to 1..MAX_DIM
    function automatic logic [DIM_W:0] clamp_dim(input logic [DREG_W-1:0] d);
        logic [DIM_W:0] r;
        if (d == '0) begin
            r = (DIM_W+1)'(1);
        end else if (32'(d) > MAX_DIM) begin
            r = (DIM_W+1)'(MAX_DIM);
        end else begin
            r = (DIM_W+1)'(d);
        end
        return r;
    endfunction

endpackage

[rtl/color_blob_centroid_steering.sv]
// ----------------------------------------------------------------------------
// color_blob_centroid_steering
// Color blob tracker: matches raster pixels against a target color, sums
// the positions of matching pixels and reports count, centroid and
// steering commands once per frame.
// ----------------------------------------------------------------------------
//
//  channel   direction  word        handshake
//  s_        in         pixel_t     s_valid / s_ready
//  m_        out        result_t    m_valid / m_ready
//  cfg_      in         index/data  cfg_valid / cfg_ready (always ready)
//
//  the front end takes one pixel per cycle; s_ready drops only while both
//  slots of the two-deep frame record queue are full
//  each frame end costs the back end four passes through the shared
//  one-bit-per-cycle divider
//  a result waits in the output register while the next frame is worked on
//  synchronous active-low reset; no clearing pass, ready from the first cycle after
//
module color_blob_centroid_steering import cbcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // pixel words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_t                s_data,

    // one result word per frame
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,

    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;

    // front end to queue
    logic       q_push;
    frame_rec_t q_push_rec;
    logic       q_full;

    // queue to back end
    logic       q_pop;
    frame_rec_t q_head;
    logic       q_empty;

    // register file, writes always taken; unused index is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_red      <= COLOR_W'(225);
            cfg_reg.target_green    <= COLOR_W'(50);
            cfg_reg.target_blue     <= COLOR_W'(75);
            cfg_reg.match_tolerance <= TOL_W'(100);
            cfg_reg.frame_width     <= DREG_W'(640);
            cfg_reg.frame_height    <= DREG_W'(480);
            cfg_reg.min_count       <= MC_W'(50);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TARGET_RED:   cfg_reg.target_red      <= cfg_data[COLOR_W-1:0];
                REG_TARGET_GREEN: cfg_reg.target_green    <= cfg_data[COLOR_W-1:0];
                REG_TARGET_BLUE:  cfg_reg.target_blue     <= cfg_data[COLOR_W-1:0];
                REG_MATCH_TOL:    cfg_reg.match_tolerance <= cfg_data[TOL_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width     <= cfg_data[DREG_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height    <= cfg_data[DREG_W-1:0];
                REG_MIN_COUNT:    cfg_reg.min_count       <= cfg_data[MC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // match, position counters, per-frame sums
    cbcs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_rec   (q_push_rec)
    );

    // finished frames waiting for the divider
    cbcs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (q_push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // centroid, steering and output register
    cbcs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/cbcs_front.sv]
// ----------------------------------------------------------------------------
// cbcs_front
// Pixel intake: color match, raster position tracking and per-frame
// accumulation; pushes one record per finished frame.
// ----------------------------------------------------------------------------
module cbcs_front import cbcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  pixel_t     s_data,
    input  logic       q_full,
    output logic       q_push,
    output frame_rec_t q_rec
);

    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;
    logic [CNT_W-1:0] hit_reg;
    logic [SUM_W-1:0] csum_reg;
    logic [SUM_W-1:0] rsum_reg;

    logic [DIM_W:0]   w_clamp;
    logic [DIM_W:0]   h_clamp;
    logic [DIM_W-1:0] w_last;
    logic [DIM_W-1:0] h_last;
    logic [TOL_W-1:0] diff;
    logic             match;
    logic             accept;
    logic             row_end;
    logic             frame_end;
    logic [CNT_W-1:0] hit_next;
    logic [SUM_W-1:0] csum_next;
    logic [SUM_W-1:0] rsum_next;

    function automatic logic [COLOR_W-1:0] absdiff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign w_clamp = clamp_dim(cfg.frame_width);
    assign h_clamp = clamp_dim(cfg.frame_height);
    assign w_last  = DIM_W'(w_clamp - (DIM_W+1)'(1));
    assign h_last  = DIM_W'(h_clamp - (DIM_W+1)'(1));

    assign diff = TOL_W'(absdiff(s_data.pixel_red, cfg.target_red))
                + TOL_W'(absdiff(s_data.pixel_green, cfg.target_green))
                + TOL_W'(absdiff(s_data.pixel_blue, cfg.target_blue));
    assign match = diff < cfg.match_tolerance;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign row_end   = col_reg >= w_last;
    assign frame_end = row_end && (row_reg >= h_last);

    assign hit_next  = hit_reg + CNT_W'(match);
    assign csum_next = match ? csum_reg + SUM_W'(col_reg) : csum_reg;
    assign rsum_next = match ? rsum_reg + SUM_W'(row_reg) : rsum_reg;

    assign q_push          = accept && frame_end;
    assign q_rec.count     = hit_next;
    assign q_rec.col_sum   = csum_next;
    assign q_rec.row_sum   = rsum_next;
    assign q_rec.width     = w_clamp;
    assign q_rec.height    = h_clamp;
    assign q_rec.min_count = cfg.min_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            hit_reg  <= '0;
            csum_reg <= '0;
            rsum_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + DIM_W'(1);
            end else begin
                col_reg <= col_reg + DIM_W'(1);
            end
            if (frame_end) begin
                hit_reg  <= '0;
                csum_reg <= '0;
                rsum_reg <= '0;
            end else begin
                hit_reg  <= hit_next;
                csum_reg <= csum_next;
                rsum_reg <= rsum_next;
            end
        end
    end

endmodule

[rtl/cbcs_queue.sv]
// ----------------------------------------------------------------------------
// cbcs_queue
// Short queue of frame records between the pixel front end and the
// centroid back end.
// ----------------------------------------------------------------------------
module cbcs_queue import cbcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output frame_rec_t head,
    output logic       empty
);

    frame_rec_t         mem_reg [QDEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = cnt_reg == Q_CNT_W'(QDEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    function automatic logic [Q_PTR_W-1:0] wrap_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(QDEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[rtl/cbcs_div.sv]
// ----------------------------------------------------------------------------
// cbcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbcs_div import cbcs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  dvs_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              take;
    logic [DEN_W-1:0]  rem_next;
    logic [NUM_W-1:0]  quo_next;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign take      = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign rem_next  = take ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    assign quo_next  = {quo_reg[NUM_W-2:0], take};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_nz   = |rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

[rtl/cbcs_back.sv]
// ----------------------------------------------------------------------------
// cbcs_back
// Frame-end arithmetic: centroid and drive commands through a shared
// divider, then the result output register.
// ----------------------------------------------------------------------------
module cbcs_back import cbcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  frame_rec_t q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_data
);

    localparam int CMP_W = CNT_W + MC_W;

    back_state_t      state_reg;
    back_state_t      state_next;
    frame_rec_t       rec_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CEN_W-1:0] cx_reg;
    logic [CEN_W-1:0] cy_reg;
    logic [CMD_W-1:0] turn_reg;
    logic [CMD_W-1:0] fwd_reg;
    logic             m_valid_reg;
    result_t          m_data_reg;

    div_req_t         div_req;
    div_rsp_t         div_rsp;
    logic [DIM_W:0]   mul_dim;
    logic [DEN_W-1:0] prod;
    logic             out_free;
    logic             load_out;
    logic             seen;
    logic             empty_frame;
    logic [NUM_W-1:0] col_x12;
    logic [NUM_W-1:0] row_x12;

    // trunc(12*s/(c*d) - 6) from q = floor(12s/cd) and remainder flag,
    // zero while its magnitude is at most one
    function automatic logic [CMD_W-1:0] drive_cmd(input logic [NUM_W-1:0] q,
                                                   input logic             r_nz);
        logic [CMD_W-1:0] v;
        if (q > NUM_W'(7) || (q == NUM_W'(7) && r_nz)) begin
            v = q[CMD_W-1:0] - CMD_W'(6);
        end else if (q < NUM_W'(5)) begin
            v = q[CMD_W-1:0] + CMD_W'(r_nz) - CMD_W'(6);
        end else begin
            v = '0;
        end
        return v;
    endfunction

    function automatic logic [MC_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(c);
        return (wide > CMP_W'({MC_W{1'b1}})) ? {MC_W{1'b1}} : wide[MC_W-1:0];
    endfunction

    cbcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign col_x12     = (NUM_W'(rec_reg.col_sum) << 3) + (NUM_W'(rec_reg.col_sum) << 2);
    assign row_x12     = (NUM_W'(rec_reg.row_sum) << 3) + (NUM_W'(rec_reg.row_sum) << 2);
    assign prod        = DEN_W'(rec_reg.count) * DEN_W'(mul_dim);
    assign out_free    = !m_valid_reg || m_ready;
    assign seen        = CMP_W'(rec_reg.count) > CMP_W'(rec_reg.min_count);
    assign empty_frame = rec_reg.count == '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (!q_empty) state_next = ST_CX_GO;
            ST_CX_GO:   state_next = ST_CX_WAIT;
            ST_CX_WAIT: if (div_rsp.done) state_next = ST_CY_GO;
            ST_CY_GO:   state_next = ST_CY_WAIT;
            ST_CY_WAIT: if (div_rsp.done) state_next = ST_TX_MUL;
            ST_TX_MUL:  state_next = ST_TX_GO;
            ST_TX_GO:   state_next = ST_TX_WAIT;
            ST_TX_WAIT: if (div_rsp.done) state_next = ST_TY_MUL;
            ST_TY_MUL:  state_next = ST_TY_GO;
            ST_TY_GO:   state_next = ST_TY_WAIT;
            ST_TY_WAIT: if (div_rsp.done) state_next = ST_EMIT;
            ST_EMIT:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop            = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = NUM_W'(rec_reg.col_sum);
        div_req.divisor  = DEN_W'(rec_reg.count);
        mul_dim          = rec_reg.width;
        case (state_reg)
            ST_IDLE: begin
                q_pop = !q_empty;
            end
            ST_CX_GO: begin
                div_req.start = 1'b1;
            end
            ST_CY_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = NUM_W'(rec_reg.row_sum);
            end
            ST_TX_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = col_x12;
                div_req.divisor  = den_reg;
            end
            ST_TY_MUL: begin
                mul_dim = rec_reg.height;
            end
            ST_TY_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = row_x12;
                div_req.divisor  = den_reg;
            end
            ST_EMIT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rec_reg <= q_head;
        end
        if (state_reg == ST_TX_MUL || state_reg == ST_TY_MUL) begin
            den_reg <= prod;
        end
        if (div_rsp.done) begin
            case (state_reg)
                ST_CX_WAIT: cx_reg   <= div_rsp.quotient[CEN_W-1:0];
                ST_CY_WAIT: cy_reg   <= div_rsp.quotient[CEN_W-1:0];
                ST_TX_WAIT: turn_reg <= CMD_W'(0) - drive_cmd(div_rsp.quotient, div_rsp.rem_nz);
                ST_TY_WAIT: fwd_reg  <= drive_cmd(div_rsp.quotient, div_rsp.rem_nz);
                default: begin
                end
            endcase
        end
        if (load_out) begin
            m_data_reg.match_count    <= sat_count(rec_reg.count);
            m_data_reg.centroid_x     <= empty_frame ? '0 : cx_reg;
            m_data_reg.centroid_y     <= empty_frame ? '0 : cy_reg;
            m_data_reg.turn_tenths    <= seen ? turn_reg : '0;
            m_data_reg.forward_tenths <= seen ? fwd_reg : '0;
            m_data_reg.target_seen    <= seen;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
